// ===== rtl/stl_pkg.sv =====
// shared types and constants for the signed trailer parser
`default_nettype none

package stl_pkg;

    localparam int unsigned MAGIC_BYTES  = 4;
    localparam int unsigned STAMP_BYTES  = 8;
    localparam int unsigned NONCE_BYTES  = 8;
    localparam int unsigned LENGTH_BYTES = 2;
    localparam int unsigned HEADER_BYTES = MAGIC_BYTES + STAMP_BYTES + NONCE_BYTES + LENGTH_BYTES;

    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LANE_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_W-1:0] STAMP_FIRST = COUNT_W'(MAGIC_BYTES);
    localparam logic [COUNT_W-1:0] NONCE_FIRST = COUNT_W'(MAGIC_BYTES + STAMP_BYTES);
    localparam logic [COUNT_W-1:0] LEN_FIRST   = COUNT_W'(MAGIC_BYTES + STAMP_BYTES + NONCE_BYTES);
    localparam logic [COUNT_W-1:0] BODY_FIRST  = COUNT_W'(HEADER_BYTES);
    localparam logic [COUNT_W-1:0] BODY_OFFSET = COUNT_W'(HEADER_BYTES - 1);

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNATURE_SIZE = 1'b1;

    localparam logic [31:0] MAGIC_RESET    = 32'h3150_4D53;
    localparam logic [15:0] SIG_SIZE_RESET = 16'd3309;

    localparam int unsigned CMD_DEPTH_DEF = 2;
    localparam int unsigned RES_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        VERDICT_NONE      = 2'd0,
        VERDICT_SIGNED    = 2'd1,
        VERDICT_UNKNOWN   = 2'd2,
        VERDICT_MALFORMED = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        SLOT_OTHER  = 2'd0,
        SLOT_STAMP  = 2'd1,
        SLOT_NONCE  = 2'd2,
        SLOT_LENGTH = 2'd3
    } t_slot;

    typedef struct packed {
        logic [7:0]         data_byte;
        t_slot              slot;
        logic [LANE_W-1:0]  lane;
        logic               is_last;
        logic               is_empty;
        logic               head_ok;
        logic               rep_seen;
        logic               short_magic;
        logic               short_header;
        logic [COUNT_W-1:0] body_len;
    } t_cmd;

    typedef struct packed {
        t_verdict    verdict;
        logic [63:0] stamp_value;
        logic [63:0] nonce_value;
        logic [15:0] sig_length;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/stl_fifo.sv =====
// small register queue with count, used between the parser stages and at the result side
`default_nettype none

module stl_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stl_front.sv =====
// front stage: takes bytes, tracks position and magic matches, classifies each item
`default_nettype none

module stl_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_last_byte,
    input  wire logic                   i_empty_trailer,
    input  wire logic [31:0]            i_magic_word,
    output stl_pkg::t_cmd               o_cmd
);

    import stl_pkg::*;

    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [23:0]        r_recent, n_recent;
    logic               r_head_match, n_head_match;
    logic               r_repeat, n_repeat;

    logic [COUNT_W-1:0] pos;
    logic [7:0]         magic_byte;
    logic [31:0]        window;
    logic               past_magic;
    logic               head_miss;
    logic               rep_hit;
    logic [COUNT_W-1:0] stamp_off;
    logic [COUNT_W-1:0] nonce_off;
    logic [COUNT_W-1:0] len_off;

    assign pos        = r_byte_count;
    assign past_magic = (pos >= STAMP_FIRST);
    assign magic_byte = i_magic_word[{pos[1:0], 3'b000} +: 8];
    assign head_miss  = ~past_magic & (magic_byte != i_data_byte);
    assign window     = {i_data_byte, r_recent};
    assign rep_hit    = past_magic & (window == i_magic_word);
    assign stamp_off  = pos - STAMP_FIRST;
    assign nonce_off  = pos - NONCE_FIRST;
    assign len_off    = pos - LEN_FIRST;

    always_comb begin
        n_head_match = r_head_match & ~head_miss;
        n_repeat     = r_repeat | rep_hit;
        n_recent     = {i_data_byte, r_recent[23:8]};
        n_byte_count = (r_byte_count == COUNT_MAX) ? r_byte_count : r_byte_count + 1'b1;

        o_cmd              = '0;
        o_cmd.data_byte    = i_data_byte;
        o_cmd.is_last      = i_last_byte;
        o_cmd.is_empty     = i_empty_trailer;
        o_cmd.head_ok      = n_head_match;
        o_cmd.rep_seen     = n_repeat;
        o_cmd.short_magic  = (pos < STAMP_FIRST - 1'b1);
        o_cmd.short_header = (pos < BODY_FIRST - 1'b1);
        o_cmd.body_len     = pos - BODY_OFFSET;
        priority if (pos < STAMP_FIRST) begin
            o_cmd.slot = SLOT_OTHER;
            o_cmd.lane = '0;
        end else if (pos < NONCE_FIRST) begin
            o_cmd.slot = SLOT_STAMP;
            o_cmd.lane = stamp_off[LANE_W-1:0];
        end else if (pos < LEN_FIRST) begin
            o_cmd.slot = SLOT_NONCE;
            o_cmd.lane = nonce_off[LANE_W-1:0];
        end else if (pos < BODY_FIRST) begin
            o_cmd.slot = SLOT_LENGTH;
            o_cmd.lane = len_off[LANE_W-1:0];
        end else begin
            o_cmd.slot = SLOT_OTHER;
            o_cmd.lane = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_recent     <= '0;
            r_head_match <= 1'b1;
            r_repeat     <= 1'b0;
        end else if (i_valid) begin
            if (i_empty_trailer || i_last_byte) begin
                r_byte_count <= '0;
                r_recent     <= '0;
                r_head_match <= 1'b1;
                r_repeat     <= 1'b0;
            end else begin
                r_byte_count <= n_byte_count;
                r_recent     <= n_recent;
                r_head_match <= n_head_match;
                r_repeat     <= n_repeat;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stl_back.sv =====
// back stage: assembles header fields and decides the verdict at the end of a trailer
`default_nettype none

module stl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire stl_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    input  wire logic [15:0]   i_signature_size,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output stl_pkg::t_result   o_res
);

    import stl_pkg::*;

    logic [63:0] r_stamp, n_stamp;
    logic [63:0] r_nonce, n_nonce;
    logic [15:0] r_length, n_length;
    logic        ends_trailer;
    t_verdict    verdict;

    assign ends_trailer = i_cmd.is_last | i_cmd.is_empty;
    assign o_cmd_pop    = i_cmd_valid & (~ends_trailer | ~i_res_full);
    assign o_res_push   = o_cmd_pop & ends_trailer;

    always_comb begin
        n_stamp  = r_stamp;
        n_nonce  = r_nonce;
        n_length = r_length;
        unique case (i_cmd.slot)
            SLOT_STAMP:  n_stamp[{i_cmd.lane, 3'b000} +: 8]  = i_cmd.data_byte;
            SLOT_NONCE:  n_nonce[{i_cmd.lane, 3'b000} +: 8]  = i_cmd.data_byte;
            SLOT_LENGTH: n_length[{i_cmd.lane[0], 3'b000} +: 8] = i_cmd.data_byte;
            default: begin
            end
        endcase
    end

    always_comb begin
        priority if (i_cmd.is_empty) begin
            verdict = VERDICT_NONE;
        end else if (i_cmd.short_magic) begin
            verdict = VERDICT_MALFORMED;
        end else if (!i_cmd.head_ok) begin
            verdict = VERDICT_UNKNOWN;
        end else if (i_cmd.short_header) begin
            verdict = VERDICT_MALFORMED;
        end else if (n_length == '0) begin
            verdict = VERDICT_MALFORMED;
        end else if (n_length != i_signature_size) begin
            verdict = VERDICT_MALFORMED;
        end else if (i_cmd.body_len != {1'b0, n_length}) begin
            verdict = VERDICT_MALFORMED;
        end else if (i_cmd.rep_seen) begin
            verdict = VERDICT_MALFORMED;
        end else begin
            verdict = VERDICT_SIGNED;
        end
    end

    always_comb begin
        o_res         = '0;
        o_res.verdict = verdict;
        if (verdict == VERDICT_SIGNED) begin
            o_res.stamp_value = n_stamp;
            o_res.nonce_value = n_nonce;
            o_res.sig_length  = n_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp  <= '0;
            r_nonce  <= '0;
            r_length <= '0;
        end else if (o_cmd_pop) begin
            if (ends_trailer) begin
                r_stamp  <= '0;
                r_nonce  <= '0;
                r_length <= '0;
            end else begin
                r_stamp  <= n_stamp;
                r_nonce  <= n_nonce;
                r_length <= n_length;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/signed_trailer_parser_unit.sv =====
// top level of the signed trailer parser: config registers, front and back stages, queues
`default_nettype none

// Takes one trailer byte per clock and returns one verdict item per trailer, on the
// byte marked last or on an empty-trailer item. A new byte is taken every cycle as long
// as the command queue between the front and back stages has room; the back stage drains
// one item per cycle and stalls only when the result queue is full. A verdict reaches the
// result side after its last byte via a command queue write, then a result queue write.
// Stamp, nonce and length read zero unless the verdict is signed. The user must write
// config registers only while no trailer is in flight; the block does not enforce it.

module signed_trailer_parser_unit #(
    parameter int unsigned CMD_DEPTH = stl_pkg::CMD_DEPTH_DEF,
    parameter int unsigned RES_DEPTH = stl_pkg::RES_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [7:0]                         i_data_byte,
    input  wire logic                               i_last_byte,
    input  wire logic                               i_empty_trailer,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [1:0]                              o_verdict,
    output logic [63:0]                             o_stamp_value,
    output logic [63:0]                             o_nonce_value,
    output logic [15:0]                             o_sig_length,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [stl_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [stl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import stl_pkg::*;

    logic [31:0] r_magic_word;
    logic [15:0] r_signature_size;

    logic    in_accept;
    t_cmd    front_cmd;
    t_cmd    back_cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    res_full;
    logic    res_push;
    t_result back_res;
    t_result out_res;

    assign in_accept = push & ~full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word     <= MAGIC_RESET;
            r_signature_size <= SIG_SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MAGIC_WORD:     r_magic_word     <= i_cfg_data[31:0];
                CFG_SIGNATURE_SIZE: r_signature_size <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    stl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_accept),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_empty_trailer (i_empty_trailer),
        .i_magic_word    (r_magic_word),
        .o_cmd           (front_cmd)
    );

    stl_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    stl_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (~cmd_empty),
        .i_cmd            (back_cmd),
        .o_cmd_pop        (cmd_pop),
        .i_signature_size (r_signature_size),
        .i_res_full       (res_full),
        .o_res_push       (res_push),
        .o_res            (back_res)
    );

    stl_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_verdict     = out_res.verdict;
    assign o_stamp_value = out_res.stamp_value;
    assign o_nonce_value = out_res.nonce_value;
    assign o_sig_length  = out_res.sig_length;

endmodule

`default_nettype wire
